// ----- design/sidr_pkg.sv -----
// ----------------------------------------------------------------------------
// sidr_pkg
// Shared types and constants of the slot ID resistor detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sidr_pkg;

	// slot geometry
	localparam int NUM_SLOTS  = 4;
	localparam int SLOT_W     = 4;
	localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// field widths
	localparam int SAMPLE_W  = 10;
	localparam int TICK_W    = 32;
	localparam int CLASS_W   = 3;
	localparam int KIND_W    = 2;
	localparam int RANGE_W   = 20;
	localparam int TRIAL_W   = 8;
	localparam int NUM_RANGES = 5;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE0  = 3'd0,
		REG_RANGE1  = 3'd1,
		REG_RANGE2  = 3'd2,
		REG_RANGE3  = 3'd3,
		REG_RANGE4  = 3'd4,
		REG_TRIAL   = 3'd5,
		REG_RESCAN  = 3'd6,
		REG_UNUSED  = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [RANGE_W-1:0] RANGE0_RST = 20'd193536;
	localparam logic [RANGE_W-1:0] RANGE1_RST = 20'd225470;
	localparam logic [RANGE_W-1:0] RANGE2_RST = 20'd301282;
	localparam logic [RANGE_W-1:0] RANGE3_RST = 20'd445740;
	localparam logic [RANGE_W-1:0] RANGE4_RST = 20'd885356;
	localparam logic [TRIAL_W-1:0] TRIAL_RST  = 8'd10;
	localparam logic [TICK_W-1:0]  RESCAN_RST = 32'd10000;

	// class and event codes
	localparam logic [CLASS_W-1:0] CLASS_EMPTY = 3'd5;

	typedef enum logic [KIND_W-1:0] {
		EV_NONE   = 2'd0,
		EV_CLOSE  = 2'd1,
		EV_OPEN   = 2'd2,
		EV_RSVD   = 2'd3
	} ev_kind_t;

	// scan sequencer phases
	typedef enum logic [6:0] {
		PH_RESET  = 7'b0000001,
		PH_START  = 7'b0000010,
		PH_REPEAT = 7'b0000100,
		PH_END    = 7'b0001000,
		PH_CLOSE  = 7'b0010000,
		PH_OPEN   = 7'b0100000,
		PH_WAIT   = 7'b1000000
	} phase_t;

	typedef logic [NUM_RANGES-1:0][RANGE_W-1:0] range_set_t;

	// one result word
	typedef struct packed {
		logic [SLOT_W-1:0]  probe_slot;
		ev_kind_t           event_kind;
		logic [SLOT_W-1:0]  event_slot;
		logic [CLASS_W-1:0] event_class;
		logic               idle_wait;
	} result_t;

endpackage

// ----- design/sidr_classify.sv -----
// ----------------------------------------------------------------------------
// sidr_classify
// Maps one ID reading to a class: five inclusive ranges in priority order,
// empty class when none matches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sidr_classify
	import sidr_pkg::*;
(
	input  range_set_t          ranges,
	input  logic [SAMPLE_W-1:0] sample,
	output logic [CLASS_W-1:0]  cls
);

	logic [NUM_RANGES-1:0] hit;

	// parallel bound compares, upper bound in the high half
	always_comb begin
		for (int c = 0; c < NUM_RANGES; c++) begin
			hit[c] = (sample >= ranges[c][SAMPLE_W-1:0]) &&
			         (sample <= ranges[c][RANGE_W-1:SAMPLE_W]);
		end
	end

	// lowest matching range wins
	always_comb begin
		cls = CLASS_EMPTY;
		for (int c = NUM_RANGES - 1; c >= 0; c--) begin
			if (hit[c]) begin
				cls = CLASS_W'(c);
			end
		end
	end

endmodule

// ----- design/sidr_out_buf.sv -----
// ----------------------------------------------------------------------------
// sidr_out_buf
// Two-entry result buffer: an output register backed by a skid register, so
// a new word is taken while the output word waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sidr_out_buf
	import sidr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop       = out_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// data words
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- design/slot_id_resistor_detector.sv -----
// ----------------------------------------------------------------------------
// slot_id_resistor_detector
// Round-robin scanner of plug-in slot ID resistors with debounced class
// changes, close/open events and a rescan wait.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid/in_ready) carries one step: the ADC reading of
//    the slot named by the last probe_slot, and the current tick time
//  - output channel (out_valid/out_ready) returns exactly one word per step:
//    next slot to probe, optional close/open event, and the wait flag
//  - the scan state updates at the accepting edge, where the result word is
//    registered into the output buffer; throughput is one step per cycle
//    while in_ready is high, set by the combinational classify and phase update
//  - a stalled receiver fills the output register, then a skid register;
//    in_ready drops only when both hold a word
//  - cfg_we writes register cfg_index from cfg_data at once; write only
//    while the block is idle
//  - reset restores register defaults, clears all slots to the empty class
//    and starts in the reset phase with the output buffer empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_id_resistor_detector
	import sidr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// step input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   id_sample,
	input  logic [TICK_W-1:0]     now_ticks,
	// result output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SLOT_W-1:0]     probe_slot,
	output logic [KIND_W-1:0]     event_kind,
	output logic [SLOT_W-1:0]     event_slot,
	output logic [CLASS_W-1:0]    event_class,
	output logic                  idle_wait
);

	localparam logic [SLOT_W:0] NUM_SLOTS_V = (SLOT_W + 1)'(NUM_SLOTS);

	// configuration registers
	range_set_t          range_q;
	logic [TRIAL_W-1:0]  trial_q;
	logic [TICK_W-1:0]   rescan_q;

	// scan state
	phase_t              phase_q;
	logic [SLOT_W-1:0]   scan_slot_q;
	logic [CLASS_W-1:0]  slot_class_q [NUM_SLOTS];
	logic [CLASS_W-1:0]  cand_q;
	logic [TRIAL_W-1:0]  repeat_q;
	logic [TICK_W-1:0]   wake_q;

	// next state
	phase_t              phase_d;
	logic [SLOT_W-1:0]   scan_slot_d;
	logic [CLASS_W-1:0]  cand_d;
	logic [TRIAL_W-1:0]  repeat_d;
	logic [TICK_W-1:0]   wake_d;
	logic                slot_we;
	logic [CLASS_W-1:0]  slot_wdata;

	logic                accept;
	logic                buf_full;
	logic [CLASS_W-1:0]  sample_cls;
	logic [CLASS_W-1:0]  stored_cls;
	logic                slot_in_range;
	logic [SLOT_W:0]     slot_inc;
	result_t             res_d;
	result_t             res_out;

	assign in_ready = !buf_full;
	assign accept   = in_valid && in_ready;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q[0] <= RANGE0_RST;
			range_q[1] <= RANGE1_RST;
			range_q[2] <= RANGE2_RST;
			range_q[3] <= RANGE3_RST;
			range_q[4] <= RANGE4_RST;
			trial_q    <= TRIAL_RST;
			rescan_q   <= RESCAN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RANGE0: range_q[0] <= cfg_data[RANGE_W-1:0];
				REG_RANGE1: range_q[1] <= cfg_data[RANGE_W-1:0];
				REG_RANGE2: range_q[2] <= cfg_data[RANGE_W-1:0];
				REG_RANGE3: range_q[3] <= cfg_data[RANGE_W-1:0];
				REG_RANGE4: range_q[4] <= cfg_data[RANGE_W-1:0];
				REG_TRIAL:  trial_q    <= cfg_data[TRIAL_W-1:0];
				REG_RESCAN: rescan_q   <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	sidr_classify u_classify (
		.ranges (range_q),
		.sample (id_sample),
		.cls    (sample_cls)
	);

	// stored class of the slot under scan
	assign slot_in_range = {1'b0, scan_slot_q} < NUM_SLOTS_V;
	assign stored_cls    = slot_in_range ? slot_class_q[scan_slot_q[SLOT_IDX_W-1:0]]
	                                     : CLASS_EMPTY;
	assign slot_inc      = {1'b0, scan_slot_q} + (SLOT_W + 1)'(1);

	// phase sequencer and result word
	always_comb begin
		phase_d     = phase_q;
		scan_slot_d = scan_slot_q;
		cand_d      = cand_q;
		repeat_d    = repeat_q;
		wake_d      = wake_q;
		slot_we     = 1'b0;
		slot_wdata  = CLASS_EMPTY;
		res_d       = '0;
		res_d.event_kind = EV_NONE;
		case (phase_q)
			PH_START: begin
				cand_d = sample_cls;
				if (sample_cls != stored_cls) begin
					repeat_d = '0;
					phase_d  = PH_REPEAT;
				end else begin
					phase_d  = PH_END;
				end
			end
			PH_REPEAT: begin
				if (sample_cls != cand_q) begin
					phase_d = PH_END;
				end else begin
					repeat_d = repeat_q + TRIAL_W'(1);
					if (repeat_q >= trial_q) begin
						phase_d = PH_CLOSE;
					end
				end
			end
			PH_CLOSE: begin
				res_d.event_kind  = EV_CLOSE;
				res_d.event_slot  = scan_slot_q;
				res_d.event_class = stored_cls;
				slot_we    = slot_in_range;
				slot_wdata = CLASS_EMPTY;
				phase_d    = PH_OPEN;
			end
			PH_OPEN: begin
				res_d.event_kind  = EV_OPEN;
				res_d.event_slot  = scan_slot_q;
				res_d.event_class = cand_q;
				slot_we    = slot_in_range;
				slot_wdata = cand_q;
				phase_d    = PH_END;
			end
			PH_END: begin
				if (slot_inc < NUM_SLOTS_V) begin
					scan_slot_d = slot_inc[SLOT_W-1:0];
					phase_d     = PH_START;
				end else begin
					scan_slot_d = '0;
					wake_d      = now_ticks + rescan_q;
					phase_d     = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (now_ticks >= wake_q) begin
					phase_d = PH_RESET;
				end
			end
			default: begin
				scan_slot_d = '0;
				phase_d     = PH_START;
			end
		endcase
		res_d.probe_slot = scan_slot_d;
		res_d.idle_wait  = (phase_d == PH_WAIT);
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RESET;
			scan_slot_q <= '0;
			cand_q      <= CLASS_EMPTY;
			repeat_q    <= '0;
			wake_q      <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			scan_slot_q <= scan_slot_d;
			cand_q      <= cand_d;
			repeat_q    <= repeat_d;
			wake_q      <= wake_d;
		end
	end

	// per-slot class table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_class_q[i] <= CLASS_EMPTY;
			end
		end else if (accept && slot_we) begin
			slot_class_q[scan_slot_q[SLOT_IDX_W-1:0]] <= slot_wdata;
		end
	end

	sidr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_d),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res_out)
	);

	assign probe_slot  = res_out.probe_slot;
	assign event_kind  = res_out.event_kind;
	assign event_slot  = res_out.event_slot;
	assign event_class = res_out.event_class;
	assign idle_wait   = res_out.idle_wait;

endmodule

// ----- design/sidr_checker.sv -----
// ----------------------------------------------------------------------------
// sidr_checker
// Port-level checks of the slot ID resistor detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sidr_checker
	import sidr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [SLOT_W-1:0]     probe_slot,
	input logic [KIND_W-1:0]     event_kind,
	input logic [SLOT_W-1:0]     event_slot,
	input logic [CLASS_W-1:0]    event_class,
	input logic                  idle_wait
);

	// after every accepted step a word is valid on the next cycle
	a_step_yields_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted step produced no output word");

	// a word stalled by the receiver holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(probe_slot) &&
		$stable(event_kind) && $stable(event_slot) && $stable(event_class) &&
		$stable(idle_wait))
		else $error("stalled output word changed");

	// word without event carries zero slot and class
	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_NONE |-> event_slot == '0 && event_class == '0)
		else $error("event fields set without an event");

	// waiting words probe slot zero and carry no event
	a_wait_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle_wait |-> probe_slot == '0 && event_kind == EV_NONE)
		else $error("wait word with event or nonzero probe slot");

	// never a reserved event kind
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_kind == EV_NONE || event_kind == EV_CLOSE ||
		event_kind == EV_OPEN)
		else $error("reserved event kind on output");

endmodule

bind slot_id_resistor_detector sidr_checker u_sidr_checker (.*);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slot ID resistor detector. A directed table
// walks one full scan (switches, a broken repeat, the rescan wait across
// the tick wrap), then randomized phases under several register settings
// drive plugged-in resistor readings per slot plus noise. Every result word
// is checked against a scan predictor, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
	import sidr_pkg::*;
();

	localparam int RUN_LIMIT = 400000;
	localparam int NUM_PHASES = 6;

	// one row of the directed table
	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic [TICK_W-1:0]   ticks;
		bit                  typed;
		logic [SLOT_W-1:0]   probe;
		ev_kind_t            kind;
		logic [SLOT_W-1:0]   slot;
		logic [CLASS_W-1:0]  cls;
		bit                  idle;
	} scan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   id_sample;
	logic [TICK_W-1:0]     now_ticks;
	logic                  out_valid;
	logic                  out_ready;
	logic [SLOT_W-1:0]     probe_slot;
	logic [KIND_W-1:0]     event_kind;
	logic [SLOT_W-1:0]     event_slot;
	logic [CLASS_W-1:0]    event_class;
	logic                  idle_wait;

	// predictor copy of registers and scan state
	logic [RANGE_W-1:0]    range_reg [NUM_RANGES];
	logic [TRIAL_W-1:0]    trial_reg;
	logic [TICK_W-1:0]     rescan_reg;
	phase_t                seq_phase;
	logic [SLOT_W-1:0]     seq_slot;
	logic [CLASS_W-1:0]    slot_cls [NUM_SLOTS];
	logic [CLASS_W-1:0]    cand_cls;
	logic [TRIAL_W-1:0]    rep_cnt;
	logic [TICK_W-1:0]     wake_at;

	// resistor currently plugged into each slot
	logic [SAMPLE_W-1:0]   plugged [NUM_SLOTS];

	result_t               awaited_words [$];
	bit                    row_typed;
	result_t               row_word;
	int                    mismatches = 0;
	int                    cycle_count = 0;
	scan_row_t             scan_rows [25];

	slot_id_resistor_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.id_sample   (id_sample),
		.now_ticks   (now_ticks),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.probe_slot  (probe_slot),
		.event_kind  (event_kind),
		.event_slot  (event_slot),
		.event_class (event_class),
		.idle_wait   (idle_wait)
	);

	always #10 clk = ~clk;

	// first range that holds the reading wins, none means empty
	function automatic logic [CLASS_W-1:0] classify_reading(logic [SAMPLE_W-1:0] sample);
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		for (int c = 0; c < NUM_RANGES; c++) begin
			lo = range_reg[c][SAMPLE_W-1:0];
			hi = range_reg[c][RANGE_W-1:SAMPLE_W];
			if (sample >= lo && sample <= hi)
				return CLASS_W'(c);
		end
		return CLASS_EMPTY;
	endfunction

	// one scan step: update state, return the word it produces
	function automatic result_t advance_scan(logic [SAMPLE_W-1:0] sample,
			logic [TICK_W-1:0] now);
		result_t w;
		logic [CLASS_W-1:0] held;
		w = '0;
		held = slot_cls[seq_slot];
		case (seq_phase)
			PH_START: begin
				cand_cls = classify_reading(sample);
				if (cand_cls != held) begin
					rep_cnt = '0;
					seq_phase = PH_REPEAT;
				end else begin
					seq_phase = PH_END;
				end
			end
			PH_REPEAT: begin
				if (classify_reading(sample) != cand_cls) begin
					seq_phase = PH_END;
				end else begin
					// limit is tested on the count before it steps
					if (rep_cnt >= trial_reg)
						seq_phase = PH_CLOSE;
					rep_cnt = rep_cnt + 1'b1;
				end
			end
			PH_CLOSE: begin
				w.event_kind = EV_CLOSE;
				w.event_slot = seq_slot;
				w.event_class = held;
				slot_cls[seq_slot] = CLASS_EMPTY;
				seq_phase = PH_OPEN;
			end
			PH_OPEN: begin
				w.event_kind = EV_OPEN;
				w.event_slot = seq_slot;
				w.event_class = cand_cls;
				slot_cls[seq_slot] = cand_cls;
				seq_phase = PH_END;
			end
			PH_END: begin
				if (int'(seq_slot) + 1 < NUM_SLOTS) begin
					seq_slot = seq_slot + 1'b1;
					seq_phase = PH_START;
				end else begin
					seq_slot = '0;
					wake_at = now + rescan_reg;
					seq_phase = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (now >= wake_at)
					seq_phase = PH_RESET;
			end
			default: begin
				seq_slot = '0;
				seq_phase = PH_START;
			end
		endcase
		w.probe_slot = seq_slot;
		w.idle_wait = (seq_phase == PH_WAIT);
		return w;
	endfunction

	// a reading inside a random class range, often on its bounds, else any reading
	function automatic logic [SAMPLE_W-1:0] pick_reading();
		int c;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		c = $urandom_range(0, NUM_RANGES);
		if (c < NUM_RANGES) begin
			lo = range_reg[c][SAMPLE_W-1:0];
			hi = range_reg[c][RANGE_W-1:SAMPLE_W];
			if (lo <= hi) begin
				case ($urandom_range(0, 3))
					0: return lo;
					1: return hi;
					default: return SAMPLE_W'($urandom_range(hi, lo));
				endcase
			end
		end
		return SAMPLE_W'($urandom_range(0, 1023));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < 40)
			$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// register write, mirrored into the predictor
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TRIAL: trial_reg = data[TRIAL_W-1:0];
			REG_RESCAN: rescan_reg = data;
			REG_UNUSED: ;
			default: range_reg[idx] = data[RANGE_W-1:0];
		endcase
		@(negedge clk);
	endtask

	// present one step word after a random gap, hold until taken
	bit send_steady = 1'b0;
	task automatic send_step(logic [SAMPLE_W-1:0] sample, logic [TICK_W-1:0] ticks,
			bit typed, result_t word);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		id_sample <= sample;
		now_ticks <= ticks;
		row_typed <= typed;
		row_word <= word;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// let every awaited word arrive, then the block's own latency
	task automatic drain_words();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// predict on each accepted step word, check each accepted result word
	always @(posedge clk) begin : scoreboard
		result_t want;
		result_t got;
		if (out_valid && out_ready) begin
			got.probe_slot = probe_slot;
			got.event_kind = ev_kind_t'(event_kind);
			got.event_slot = event_slot;
			got.event_class = event_class;
			got.idle_wait = idle_wait;
			if (awaited_words.size() == 0) begin
				report_mismatch("word with nothing awaited", got, 0);
			end else begin
				want = awaited_words.pop_front();
				if (probe_slot !== want.probe_slot)
					report_mismatch("probe_slot", probe_slot, want.probe_slot);
				if (event_kind !== want.event_kind)
					report_mismatch("event_kind", event_kind, want.event_kind);
				if (event_slot !== want.event_slot)
					report_mismatch("event_slot", event_slot, want.event_slot);
				if (event_class !== want.event_class)
					report_mismatch("event_class", event_class, want.event_class);
				if (idle_wait !== want.idle_wait)
					report_mismatch("idle_wait", idle_wait, want.idle_wait);
			end
		end
		if (in_valid && in_ready) begin
			want = advance_scan(id_sample, now_ticks);
			if (row_typed)
				want = row_word;
			awaited_words.push_back(want);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("slot_id_resistor_detector: mismatch");
			$finish;
		end
	end

	// result side: random stall before taking each word
	initial begin : word_sink
		int stall;
		bit steady;
		steady = 1'b0;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 59) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// step side: directed table, then randomized phases
	initial begin : stimulus
		logic [RANGE_W-1:0]  rng [NUM_RANGES];
		logic [TRIAL_W-1:0]  trl;
		logic [TICK_W-1:0]   ivl;
		logic [TICK_W-1:0]   tick;
		logic [SAMPLE_W-1:0] smp;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		result_t             w;
		int                  noise;
		int                  count;
		int                  phase_items [NUM_PHASES];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		id_sample = '0;
		now_ticks = '0;
		row_typed = 1'b0;
		row_word = '0;

		// predictor reset state
		range_reg[0] = RANGE0_RST;
		range_reg[1] = RANGE1_RST;
		range_reg[2] = RANGE2_RST;
		range_reg[3] = RANGE3_RST;
		range_reg[4] = RANGE4_RST;
		trial_reg = TRIAL_RST;
		rescan_reg = RESCAN_RST;
		seq_phase = PH_RESET;
		seq_slot = '0;
		for (int s = 0; s < NUM_SLOTS; s++)
			slot_cls[s] = CLASS_EMPTY;
		cand_cls = CLASS_EMPTY;
		rep_cnt = '0;
		wake_at = '0;

		// default ranges: 0..189, 190..220, 226..294, 300..435, 620..864
		scan_rows = '{
			'{10'd512,  32'd0,          1'b1, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd0,    32'd1,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd189,  32'd2,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd1023, 32'd3,          1'b1, 4'd0, EV_CLOSE, 4'd0, CLASS_EMPTY, 1'b0},
			'{10'd0,    32'd4,          1'b1, 4'd0, EV_OPEN,  4'd0, 3'd0,        1'b0},
			'{10'd1023, 32'd5,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd1023, 32'd6,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd0,    32'd7,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd864,  32'd8,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd620,  32'd9,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd0,    32'd10,         1'b1, 4'd2, EV_CLOSE, 4'd2, CLASS_EMPTY, 1'b0},
			'{10'd1023, 32'd11,         1'b1, 4'd2, EV_OPEN,  4'd2, 3'd4,        1'b0},
			'{10'd0,    32'd12,         1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd221,  32'd13,         1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd0,    32'hFFFF_FFFE,  1'b1, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b1},
			'{10'd1023, 32'd1,          1'b1, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b1},
			'{10'd0,    32'd2,          1'b1, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd512,  32'd3,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd300,  32'd4,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd295,  32'd5,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd0,    32'd6,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd220,  32'd7,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd190,  32'd8,          1'b0, 4'd0, EV_NONE,  4'd0, 3'd0,        1'b0},
			'{10'd0,    32'd9,          1'b1, 4'd1, EV_CLOSE, 4'd1, CLASS_EMPTY, 1'b0},
			'{10'd0,    32'd10,         1'b1, 4'd1, EV_OPEN,  4'd1, 3'd1,        1'b0}
		};
		phase_items = '{200, 200, 200, 500, 200, 200};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed scan: switch on the first repeat, short rescan wait
		write_reg(REG_UNUSED, $urandom);
		write_reg(REG_TRIAL, 32'd0);
		write_reg(REG_RESCAN, 32'd4);
		cfg_we <= 1'b0;
		foreach (scan_rows[r]) begin
			w.probe_slot = scan_rows[r].probe;
			w.event_kind = scan_rows[r].kind;
			w.event_slot = scan_rows[r].slot;
			w.event_class = scan_rows[r].cls;
			w.idle_wait = scan_rows[r].idle;
			send_step(scan_rows[r].sample, scan_rows[r].ticks, scan_rows[r].typed, w);
		end

		tick = 32'd100;
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_words();

			// register setting of this phase
			case (p)
				0: begin
					rng = '{RANGE0_RST, RANGE1_RST, RANGE2_RST, RANGE3_RST, RANGE4_RST};
					trl = TRIAL_RST;
					ivl = RESCAN_RST;
					noise = 20;
				end
				1: begin
					// every range covers everything: all readings are class 0
					rng = '{default: 20'hFFC00};
					trl = 8'd0;
					ivl = 32'd0;
					noise = 8;
				end
				2: begin
					// every range has lower above upper: all readings are empty
					rng = '{default: 20'h003FF};
					trl = 8'd1;
					ivl = 32'hFFFF_FFFF;
					noise = 8;
				end
				3: begin
					// longest debounce, counter wraps on the switch
					rng = '{RANGE0_RST, RANGE1_RST, RANGE2_RST, RANGE3_RST, RANGE4_RST};
					trl = 8'd255;
					ivl = $urandom_range(0, 100);
					noise = 0;
				end
				default: begin
					for (int c = 0; c < NUM_RANGES; c++) begin
						lo = $urandom_range(0, 1023);
						hi = $urandom_range(0, 1023);
						if (lo > hi && $urandom_range(0, 3) != 0) begin
							rng[c] = {lo, hi};
						end else begin
							rng[c] = {hi, lo};
						end
					end
					trl = $urandom_range(0, 4);
					ivl = $urandom_range(0, 300);
					noise = 16;
				end
			endcase
			write_reg(REG_UNUSED, $urandom);
			for (int c = 0; c < NUM_RANGES; c++)
				write_reg(cfg_reg_t'(c), ($urandom << RANGE_W) | CFG_DATA_W'(rng[c]));
			write_reg(REG_TRIAL, ($urandom << TRIAL_W) | CFG_DATA_W'(trl));
			write_reg(REG_RESCAN, ivl);
			cfg_we <= 1'b0;
			for (int s = 0; s < NUM_SLOTS; s++)
				plugged[s] = pick_reading();

			count = 0;
			while (count < phase_items[p]) begin
				if ($urandom_range(0, 59) == 0)
					send_steady = !send_steady;
				// swap resistors only between scans so repeats stay clean
				if (seq_phase == PH_WAIT && $urandom_range(0, 1) == 0)
					plugged[$urandom_range(0, NUM_SLOTS - 1)] = pick_reading();
				if ((seq_phase == PH_START || seq_phase == PH_REPEAT) &&
						(noise == 0 || $urandom_range(1, noise) != 1)) begin
					smp = plugged[seq_slot];
				end else begin
					smp = $urandom_range(0, 1023);
				end
				// ticks mostly creep, sometimes land on the wake time or jump
				if (seq_phase == PH_WAIT && $urandom_range(0, 3) == 0) begin
					tick = wake_at + $urandom_range(0, 2);
				end else if ($urandom_range(0, 63) == 0) begin
					tick = $urandom;
				end else begin
					tick = tick + $urandom_range(0, 50);
				end
				send_step(smp, tick, 1'b0, '0);
				count++;
			end
		end

		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("slot_id_resistor_detector: match");
		end else begin
			$display("slot_id_resistor_detector: mismatch");
		end
		$finish;
	end

endmodule
